/* rtl/utf8v_pkg.sv */
package utf8v_pkg;

	// Largest number of bytes that one input word can produce.
	localparam int RunDepth = 6;

	// Replacement character U+FFFD in UTF-8.
	localparam logic [7:0] ReplB0 = 8'hEF;
	localparam logic [7:0] ReplB1 = 8'hBF;
	localparam logic [7:0] ReplB2 = 8'hBD;

	// Lead byte ranges.
	localparam logic [7:0] AsciiTop = 8'h80;
	localparam logic [7:0] Lead2Lo  = 8'hC2;
	localparam logic [7:0] Lead2Hi  = 8'hDF;
	localparam logic [7:0] LeadE0   = 8'hE0;
	localparam logic [7:0] LeadEd   = 8'hED;
	localparam logic [7:0] Lead3Hi  = 8'hEF;
	localparam logic [7:0] LeadF0   = 8'hF0;
	localparam logic [7:0] LeadF4   = 8'hF4;

	// Continuation byte ranges, with the narrowed second-byte limits.
	localparam logic [7:0] ContLo = 8'h80;
	localparam logic [7:0] ContHi = 8'hBF;
	localparam logic [7:0] E0Lo   = 8'hA0;
	localparam logic [7:0] EdHi   = 8'h9F;
	localparam logic [7:0] F0Lo   = 8'h90;
	localparam logic [7:0] F4Hi   = 8'h8F;

	// Sequence length codes.
	localparam logic [2:0] LenBad   = 3'd0;
	localparam logic [2:0] LenOne   = 3'd1;
	localparam logic [2:0] LenTwo   = 3'd2;
	localparam logic [2:0] LenThree = 3'd3;
	localparam logic [2:0] LenFour  = 3'd4;

	// Input word as it sits in the input buffer.
	typedef struct packed {
		logic [7:0] data;
		logic       cmd;
	} word_t;

	// Classification of a lead byte.
	typedef struct packed {
		logic [2:0] len;
		logic [7:0] lo;
		logic [7:0] hi;
	} lead_t;

	// All output bytes caused by one input word.
	typedef struct packed {
		logic [RunDepth-1:0][7:0] bytes;
		logic [2:0]               count;
	} run_t;

	// Decoder state seen from outside.
	typedef struct packed {
		logic [1:0] held_count;
		logic [2:0] seq_length;
	} core_status_t;

	// Expected length of a sequence from its lead byte, and the allowed
	// range of its second byte.
	function automatic lead_t lead_class(input logic [7:0] b);
		lead_t r;
		r.len = LenBad;
		r.lo  = ContLo;
		r.hi  = ContHi;
		if (b < AsciiTop) begin
			r.len = LenOne;
		end else if (b >= Lead2Lo && b <= Lead2Hi) begin
			r.len = LenTwo;
		end else if (b >= LeadE0 && b <= Lead3Hi) begin
			r.len = LenThree;
			if (b == LeadE0) r.lo = E0Lo;
			if (b == LeadEd) r.hi = EdHi;
		end else if (b >= LeadF0 && b <= LeadF4) begin
			r.len = LenFour;
			if (b == LeadF0) r.lo = F0Lo;
			if (b == LeadF4) r.hi = F4Hi;
		end
		return r;
	endfunction

endpackage

/* rtl/utf8v_skid.sv */
module utf8v_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  utf8v_pkg::word_t in_word,
	output logic             head_valid,
	output utf8v_pkg::word_t head,
	input  logic             pop
);
	import utf8v_pkg::*;

	word_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	// Ready comes from the fill count alone, so it does not wait on the output side.
	assign in_ready   = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_q];
	assign push       = in_valid && in_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_word;
	end

endmodule

/* rtl/utf8v_core.sv */
module utf8v_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  utf8v_pkg::word_t        word,
	input  logic                    go,
	output utf8v_pkg::run_t         run,
	output utf8v_pkg::core_status_t st
);
	import utf8v_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] hc_q;
	logic [2:0] sl_q;

	logic [1:0] hc_d;
	logic [2:0] sl_d;
	logic       hold_wr;
	logic [1:0] hold_idx;
	logic [7:0] b;
	lead_t      lb;
	lead_t      lh;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       in_rng;
	logic       complete;
	logic       do_start;
	logic [2:0] base;
	run_t       r;

	assign run           = r;
	assign st.held_count = hc_q;
	assign st.seq_length = sl_q;

	// Decode one word against the held bytes.
	always_comb begin
		b        = word.data;
		lb       = lead_class(b);
		lh       = lead_class(held_q[0]);
		r        = '0;
		hc_d     = hc_q;
		sl_d     = sl_q;
		hold_wr  = 1'b0;
		hold_idx = hc_q;
		do_start = 1'b0;
		base     = 3'd0;
		lo       = (hc_q == 2'd1) ? lh.lo : ContLo;
		hi       = (hc_q == 2'd1) ? lh.hi : ContHi;
		in_rng   = (b >= lo) && (b <= hi);
		complete = (({1'b0, hc_q} + 3'd1) == sl_q);

		if (word.cmd) begin
			// Flush: an unfinished tail becomes one replacement.
			if (hc_q != 2'd0) begin
				r.bytes[0] = ReplB0;
				r.bytes[1] = ReplB1;
				r.bytes[2] = ReplB2;
				r.count    = 3'd3;
				hc_d       = 2'd0;
				sl_d       = LenBad;
			end
		end else if (hc_q == 2'd0 || sl_q < LenTwo || sl_q > LenFour) begin
			do_start = 1'b1;
		end else if (in_rng) begin
			if (complete) begin
				// Sequence done: release the held bytes and this one.
				r.bytes[0] = held_q[0];
				r.bytes[1] = (hc_q >= 2'd2) ? held_q[1] : b;
				r.bytes[2] = (hc_q == 2'd3) ? held_q[2] : b;
				r.bytes[3] = b;
				r.count    = {1'b0, hc_q} + 3'd1;
				hc_d       = 2'd0;
				sl_d       = LenBad;
			end else begin
				hold_wr = (hc_q != 2'd3);
				hc_d    = hc_q + 2'd1;
			end
		end else begin
			// Bad continuation: replace the held part, then restart on this byte.
			r.bytes[0] = ReplB0;
			r.bytes[1] = ReplB1;
			r.bytes[2] = ReplB2;
			r.count    = 3'd3;
			base       = 3'd3;
			do_start   = 1'b1;
		end

		// Treat the byte as the start of a new sequence.
		if (do_start) begin
			hc_d = 2'd0;
			sl_d = LenBad;
			case (lb.len)
				LenOne: begin
					r.bytes[base] = b;
					r.count       = base + 3'd1;
				end
				LenBad: begin
					r.bytes[base]        = ReplB0;
					r.bytes[base + 3'd1] = ReplB1;
					r.bytes[base + 3'd2] = ReplB2;
					r.count              = base + 3'd3;
				end
				default: begin
					hold_wr  = 1'b1;
					hold_idx = 2'd0;
					hc_d     = 2'd1;
					sl_d     = lb.len;
				end
			endcase
		end
	end

	// Sequence tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= 2'd0;
			sl_q <= LenBad;
		end else if (go) begin
			hc_q <= hc_d;
			sl_q <= sl_d;
		end
	end

	// Held bytes of the open sequence.
	always_ff @(posedge clk) begin
		if (go && hold_wr) held_q[hold_idx] <= b;
	end

endmodule

/* rtl/utf8v_emit.sv */
module utf8v_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  utf8v_pkg::run_t run,
	input  logic            load,
	output logic            load_ok,
	output logic            tvalid,
	input  logic            tready,
	output logic [7:0]      tdata,
	output logic            tlast
);
	import utf8v_pkg::*;

	logic [RunDepth-1:0][7:0] buf_q;
	logic [2:0]               cnt_q;
	logic [2:0]               idx_q;
	logic                     vld_q;
	logic                     take;
	logic                     last;

	assign take    = vld_q && tready;
	assign last    = (idx_q == (cnt_q - 3'd1));
	assign load_ok = !vld_q || (take && last);
	assign tvalid  = vld_q;
	assign tdata   = buf_q[idx_q];
	assign tlast   = last;

	// Step through the run one byte per accepted transfer; reload as the last one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else begin
			if (load && run.count != 3'd0) begin
				vld_q <= 1'b1;
				cnt_q <= run.count;
				idx_q <= 3'd0;
			end else if (take && last) begin
				vld_q <= 1'b0;
			end else if (take) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Run bytes.
	always_ff @(posedge clk) begin
		if (load && run.count != 3'd0) buf_q <= run.bytes;
	end

endmodule

/* rtl/utf8_stream_validate_replace.sv */
// UTF-8 stream repair. Bytes enter on s_axis with tuser = 0; a word with
// tuser = 1 is an end-of-stream flush whose tdata is ignored. Well-formed
// sequences leave on m_axis unchanged once their last byte has arrived;
// each maximal invalid subpart leaves as EF BF BD, and a flush turns an
// unfinished tail into one EF BF BD. m_axis_tlast marks the final output
// byte caused by an input word; a word that only extends a held sequence,
// or a flush with nothing held, causes no output. An input word passes a
// two-entry buffer and, once it is at the buffer head and the output
// register is free, is decoded combinationally and loaded into the output
// register, from which its first byte is offered on m_axis. A word that
// yields n output bytes (0 to 6) holds the output register until all n
// have left; the input side takes one word per cycle as long as the
// output side drains one byte per cycle and each word yields at most one.
module utf8_stream_validate_replace (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] cmd
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);
	import utf8v_pkg::*;

	word_t        in_word;
	word_t        head;
	logic         head_valid;
	logic         load_ok;
	logic         go;
	run_t         run;
	core_status_t st;

	assign in_word.data = s_axis_tdata;
	assign in_word.cmd  = s_axis_tuser[0];
	assign go           = head_valid && load_ok;

	// Input buffer.
	utf8v_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_word    (in_word),
		.head_valid (head_valid),
		.head       (head),
		.pop        (go)
	);

	// Sequence decoder.
	utf8v_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (head),
		.go     (go),
		.run    (run),
		.st     (st)
	);

	// Output serializer.
	utf8v_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.run     (run),
		.load    (go),
		.load_ok (load_ok),
		.tvalid  (m_axis_tvalid),
		.tready  (m_axis_tready),
		.tdata   (m_axis_tdata),
		.tlast   (m_axis_tlast)
	);

	// A sequence length is recorded exactly when bytes are held.
	a_len_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st.held_count == 2'd0) == (st.seq_length == LenBad))
		else $error("sequence length and held count disagree");

	// A flush always leaves nothing held.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && head.cmd |=> st.held_count == 2'd0)
		else $error("flush left bytes held");

	// A data byte that produces no output must have been held.
	a_silent_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		go && !head.cmd && run.count == 3'd0 |=> st.held_count != 2'd0)
		else $error("data byte dropped without output or hold");

endmodule
